[design/uhl_pkg.sv]
// Shared types and constants for the UUID hash lookup-or-insert engine.
package uhl_pkg;

    // Default table geometry
    localparam int BUCKETS_DEF     = 256;
    localparam int MAX_ENTRIES_DEF = 1024;

    // Key and hash geometry
    localparam int KEY_W       = 64;
    localparam int HASH_W      = 64;
    localparam int HASH_BYTES  = 16;
    localparam int INDEX_OUT_W = 10;

    // Input word: one 128-bit key as two halves
    typedef struct packed {
        logic [KEY_W-1:0] uuid_high;
        logic [KEY_W-1:0] uuid_low;
    } t_in;

    // Output word: entry index plus outcome flags
    typedef struct packed {
        logic [INDEX_OUT_W-1:0] entry_index;
        logic                   created;
        logic                   failed;
    } t_out;

    // Main sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD_CHK,
        S_WALK,
        S_MISS,
        S_RESULT
    } t_state;

    // Hash unit states
    typedef enum logic [1:0] {
        H_IDLE,
        H_BYTES,
        H_REDUCE,
        H_DONE
    } t_hash_state;

endpackage

[design/uhl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module uhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/uhl_hash.sv]
// Iterative key hash (h = 31*h + byte over 16 bytes) and bucket reduction.
module uhl_hash #(
    parameter int BUCKETS = uhl_pkg::BUCKETS_DEF,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  uhl_pkg::t_in  i_key,
    output logic          o_done,
    output logic [BW-1:0] o_bucket
);
    import uhl_pkg::*;

    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int CNT_W   = 6;

    t_hash_state        r_state, n_state;
    logic [HASH_W-1:0]  r_h, n_h;
    logic [2*KEY_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BW:0]        r_rem, n_rem;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [HASH_W-1:0]  h_step;
    logic [BW:0]        rem_shift;

    // One hash step: 31*h + byte, wrapping at 64 bits
    assign h_step = (r_h << 5) - r_h + HASH_W'(r_sh[2*KEY_W-1 -: 8]);

    // One restoring step of h mod BUCKETS, MSB first
    assign rem_shift = {r_rem[BW-1:0], r_h[HASH_W-1]};

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_h      <= n_h;
        r_sh     <= n_sh;
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_bucket <= n_bucket;
    end

    // Sequence bytes, then reduce
    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_sh     = r_sh;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_bucket = r_bucket;
        o_done   = 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_h     = '0;
                    n_sh    = {i_key.uuid_high, i_key.uuid_low};
                    n_cnt   = '0;
                    n_state = H_BYTES;
                end
            end
            H_BYTES: begin
                n_h   = h_step;
                n_sh  = r_sh << 8;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_BYTES - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (IS_POW2) begin
                        n_bucket = BW'(h_step & HASH_W'(BUCKETS - 1));
                        n_state  = H_DONE;
                    end else begin
                        n_state = H_REDUCE;
                    end
                end
            end
            H_REDUCE: begin
                n_h   = r_h << 1;
                n_cnt = r_cnt + 1'b1;
                if (rem_shift >= (BW+1)'(BUCKETS)) begin
                    n_rem = rem_shift - (BW+1)'(BUCKETS);
                end else begin
                    n_rem = rem_shift;
                end
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    n_bucket = n_rem[BW-1:0];
                    n_state  = H_DONE;
                end
            end
            H_DONE: begin
                o_done  = 1'b1;
                n_state = H_IDLE;
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

    assign o_bucket = r_bucket;

endmodule

[design/uuid_hash_lookup_or_insert.sv]
// Top level: find-or-insert engine for 128-bit keys over a chained hash table.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (uuid_high, uuid_low)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (entry_index, created, failed)
//
// Each key passes through: the accept step, the hash unit (16 bytes plus a done step),
// one bucket-head check, one entry-RAM read and key compare per chain node visited, an
// insert step on a miss and one hand-off step. When BUCKETS is not a power of two the
// hash unit adds a bucket reduction of one bit a cycle over the 64-bit hash. After reset
// the bucket-head RAM is cleared one bucket a cycle; o_in_ready stays low until that pass
// ends. One key is in flight at a time; the hand-off waits while the output register
// holds an untaken result, and the next key is taken while the previous result still
// waits there.
module uuid_hash_lookup_or_insert #(
    parameter int BUCKETS     = uhl_pkg::BUCKETS_DEF,
    parameter int MAX_ENTRIES = uhl_pkg::MAX_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  uhl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output uhl_pkg::t_out o_out_data
);
    import uhl_pkg::*;

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW  = $clog2(MAX_ENTRIES + 1);
    localparam int LW  = IW + 1;
    localparam int EW  = 2 * KEY_W + LW;

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key_hi, n_key_hi;
    logic [KEY_W-1:0] r_key_lo, n_key_lo;
    logic [LW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_idx, n_idx;
    logic [UW-1:0]    r_used, n_used;
    logic [BW-1:0]    r_clr, n_clr;
    t_out             r_res, n_res;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             hash_start;
    logic             hash_done;
    logic [BW-1:0]    hash_bucket;
    t_in              hash_key;

    logic             bkt_we;
    logic [BW-1:0]    bkt_waddr;
    logic [LW-1:0]    bkt_wdata;
    logic [LW-1:0]    bkt_rdata;

    logic             ent_we;
    logic [IW-1:0]    ent_raddr;
    logic [EW-1:0]    ent_rdata;
    logic [KEY_W-1:0] ent_key_hi;
    logic [KEY_W-1:0] ent_key_lo;
    logic [LW-1:0]    ent_link;
    logic [IW-1:0]    used_idx;
    logic             key_match;
    logic             out_load;

    // Hash unit, started with the word being accepted
    assign hash_key.uuid_high = i_in_data.uuid_high;
    assign hash_key.uuid_low  = i_in_data.uuid_low;

    uhl_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (hash_key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    // Bucket heads: valid bit plus entry index
    uhl_ram #(
        .WIDTH (LW),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (hash_bucket),
        .o_rdata (bkt_rdata)
    );

    // Entries: key halves plus next link
    uhl_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (used_idx),
        .i_wdata ({r_key_hi, r_key_lo, r_head}),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    assign ent_key_hi = ent_rdata[EW-1 -: KEY_W];
    assign ent_key_lo = ent_rdata[EW-KEY_W-1 -: KEY_W];
    assign ent_link   = ent_rdata[LW-1:0];
    assign key_match  = (ent_key_hi == r_key_hi) && (ent_key_lo == r_key_lo);
    assign used_idx   = r_used[IW-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key_hi <= n_key_hi;
        r_key_lo <= n_key_lo;
        r_head   <= n_head;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // Sequencer: clear, hash, walk the chain, insert, hand off
    always_comb begin
        n_state    = r_state;
        n_key_hi   = r_key_hi;
        n_key_lo   = r_key_lo;
        n_head     = r_head;
        n_idx      = r_idx;
        n_used     = r_used;
        n_clr      = r_clr;
        n_res      = r_res;
        hash_start = 1'b0;
        bkt_we     = 1'b0;
        bkt_waddr  = hash_bucket;
        bkt_wdata  = {1'b1, used_idx};
        ent_we     = 1'b0;
        ent_raddr  = r_idx;
        out_load   = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = r_clr;
                bkt_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_key_hi   = i_in_data.uuid_high;
                    n_key_lo   = i_in_data.uuid_low;
                    hash_start = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                // bucket RAM reads the finished bucket on this edge
                if (hash_done) begin
                    n_state = S_HEAD_CHK;
                end
            end
            S_HEAD_CHK: begin
                n_head = bkt_rdata;
                if (bkt_rdata[LW-1]) begin
                    ent_raddr = bkt_rdata[IW-1:0];
                    n_idx     = bkt_rdata[IW-1:0];
                    n_state   = S_WALK;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_WALK: begin
                if (key_match) begin
                    n_res.entry_index = INDEX_OUT_W'(r_idx);
                    n_res.created     = 1'b0;
                    n_res.failed      = 1'b0;
                    n_state           = S_RESULT;
                end else if (ent_link[LW-1]) begin
                    // advance to the next node
                    ent_raddr = ent_link[IW-1:0];
                    n_idx     = ent_link[IW-1:0];
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (r_used == UW'(MAX_ENTRIES)) begin
                    n_res.entry_index = '0;
                    n_res.created     = 1'b0;
                    n_res.failed      = 1'b1;
                end else begin
                    // store key, push entry on the bucket head
                    ent_we            = 1'b1;
                    bkt_we            = 1'b1;
                    n_used            = r_used + 1'b1;
                    n_res.entry_index = INDEX_OUT_W'(used_idx);
                    n_res.created     = 1'b1;
                    n_res.failed      = 1'b0;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a result, drop it once taken
    always_comb begin
        n_out_valid = out_load | (r_out_valid & ~i_out_ready);
        n_out       = out_load ? r_res : r_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result never claims both a new entry and a full pool
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.created && o_out_data.failed))
        else $error("created and failed both set");

    // A failed result carries index zero
    a_failed_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.failed) |-> (o_out_data.entry_index == '0))
        else $error("failed result with nonzero index");

    // An accepted key starts the hash unit
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_HASH))
        else $error("accepted key did not start hashing");

    // The pool counter moves only on an insert
    a_used_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_used != $past(r_used))) |->
            (($past(r_state) == S_MISS) && (r_used == $past(r_used) + 1'b1)))
        else $error("pool counter changed outside an insert");

endmodule
